[design/ray_triangle_intersect_macros.svh]
// Assertion macros shared by the ray/triangle intersection design.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RTI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rti_pkg.sv]
// Package for the ray/triangle intersection block: widths, register indexes
// and the sideband types passed between the datapath and the divider.
package rti_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int FRAC_BITS      = 12;
    localparam int NORM_WIDTH     = 16;
    localparam int EPS_WIDTH      = 16;
    localparam int APB_ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        REG_ORG_X    = 3'd0,
        REG_ORG_Y    = 3'd1,
        REG_ORG_Z    = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_DET_EPS  = 3'd6,
        REG_DIST_EPS = 3'd7
    } rti_reg_t;

    typedef struct packed {
        logic signed [NORM_WIDTH-1:0] x;
        logic signed [NORM_WIDTH-1:0] y;
        logic signed [NORM_WIDTH-1:0] z;
    } rti_norm_t;

    typedef struct packed {
        logic      ok;
        logic      sat;
        rti_norm_t norm;
    } rti_side_t;

endpackage

[design/rti_tri_if.sv]
// Triangle input channel: three vertices and a unit face normal.
// Depends on rti_pkg for the default widths.
interface rti_tri_if #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH
);
    logic                                  valid;
    logic                                  ready;
    logic signed [COORD_WIDTH-1:0]         vert0_x;
    logic signed [COORD_WIDTH-1:0]         vert0_y;
    logic signed [COORD_WIDTH-1:0]         vert0_z;
    logic signed [COORD_WIDTH-1:0]         vert1_x;
    logic signed [COORD_WIDTH-1:0]         vert1_y;
    logic signed [COORD_WIDTH-1:0]         vert1_z;
    logic signed [COORD_WIDTH-1:0]         vert2_x;
    logic signed [COORD_WIDTH-1:0]         vert2_y;
    logic signed [COORD_WIDTH-1:0]         vert2_z;
    logic signed [rti_pkg::NORM_WIDTH-1:0] face_norm_x;
    logic signed [rti_pkg::NORM_WIDTH-1:0] face_norm_y;
    logic signed [rti_pkg::NORM_WIDTH-1:0] face_norm_z;

    modport source (
        output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
               vert2_x, vert2_y, vert2_z, face_norm_x, face_norm_y, face_norm_z,
        input  ready
    );

    modport sink (
        input  valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
               vert2_x, vert2_y, vert2_z, face_norm_x, face_norm_y, face_norm_z,
        output ready
    );
endinterface

[design/rti_hit_if.sv]
// Result channel: hit flag, distance along the ray and the face normal.
// Depends on rti_pkg for the default widths.
interface rti_hit_if #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH
);
    logic                                  valid;
    logic                                  ready;
    logic                                  hit;
    logic [COORD_WIDTH-2:0]                hit_distance;
    logic signed [rti_pkg::NORM_WIDTH-1:0] hit_norm_x;
    logic signed [rti_pkg::NORM_WIDTH-1:0] hit_norm_y;
    logic signed [rti_pkg::NORM_WIDTH-1:0] hit_norm_z;

    modport source (
        output valid, hit, hit_distance, hit_norm_x, hit_norm_y, hit_norm_z,
        input  ready
    );

    modport sink (
        input  valid, hit, hit_distance, hit_norm_x, hit_norm_y, hit_norm_z,
        output ready
    );
endinterface

[design/rti_div.sv]
// Pipelined restoring divider that produces one quotient bit per stage.
// Depends on rti_pkg for the sideband type carried with each word.
module rti_div #(
    parameter int DET_W = 65,
    parameter int NUM_W = 77,
    parameter int QUO_W = 23
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rti_pkg::rti_side_t in_side,
    input  logic [DET_W-1:0]   in_det,
    input  logic [NUM_W-1:0]   in_num,
    output logic               out_valid,
    input  logic               out_ready,
    output rti_pkg::rti_side_t out_side,
    output logic [QUO_W-1:0]   out_quo
);

    localparam int REM_W = (NUM_W > DET_W + QUO_W) ? NUM_W : DET_W + QUO_W;

    logic [QUO_W-1:0]   vld_reg;
    logic [QUO_W-1:0]   en;
    logic [REM_W-1:0]   rem_reg  [QUO_W];
    logic [QUO_W-1:0]   quo_reg  [QUO_W];
    logic [DET_W-1:0]   det_reg  [QUO_W];
    rti_pkg::rti_side_t side_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;
        logic               vld_up;
        logic [REM_W-1:0]   rem_up;
        logic [QUO_W-1:0]   quo_up;
        logic [DET_W-1:0]   det_up;
        rti_pkg::rti_side_t side_up;
        logic [REM_W-1:0]   trial;
        logic [REM_W:0]     diff;
        logic               ge;

        if (k == 0) begin : g_first
            assign vld_up  = in_valid;
            assign rem_up  = REM_W'(in_num);
            assign quo_up  = '0;
            assign det_up  = in_det;
            assign side_up = in_side;
        end
        else begin : g_inner
            assign vld_up  = vld_reg[k-1];
            assign rem_up  = rem_reg[k-1];
            assign quo_up  = quo_reg[k-1];
            assign det_up  = det_reg[k-1];
            assign side_up = side_reg[k-1];
        end

        if (k == QUO_W - 1) begin : g_last_en
            assign en[k] = !vld_reg[k] || out_ready;
        end
        else begin : g_mid_en
            assign en[k] = !vld_reg[k] || en[k+1];
        end

        assign trial = REM_W'(det_up) << BIT;
        assign diff  = {1'b0, rem_up} - {1'b0, trial};
        assign ge    = !diff[REM_W];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                vld_reg[k] <= vld_up;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= ge ? diff[REM_W-1:0] : rem_up;
                quo_reg[k]  <= quo_up | (ge ? (QUO_W'(1) << BIT) : '0);
                det_reg[k]  <= det_up;
                side_reg[k] <= side_up;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];

endmodule

[design/ray_triangle_intersect.sv]
// Top level of the ray/triangle intersection block with its APB register file.
// Depends on rti_pkg, rti_tri_if, rti_hit_if, rti_div and the assertion macros.
//
// Each triangle word gets one result word, in order, with no dependence between
// words: a new triangle can be accepted every cycle unless output back-pressure
// has filled the pipeline. The pipeline has seven arithmetic stages (edges,
// cross products, cross scaling, dot products, sums, sign fix, range checks),
// one divider stage per distance bit, and the output register. The divider,
// which resolves one quotient bit per stage, sets the depth. Stages with no word
// in them absorb stalls, so input keeps flowing while a finished result waits.
// The ray and the thresholds must be written over APB only while the block holds
// no word; the block itself does not enforce this.
`include "ray_triangle_intersect_macros.svh"

module ray_triangle_intersect #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = rti_pkg::FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rti_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [rti_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [rti_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,
    rti_tri_if.sink                             triangle,
    rti_hit_if.source                           result
);

    localparam int CW    = COORD_WIDTH;
    localparam int EW    = CW + 1;
    localparam int PHW   = CW + EW;
    localparam int PQW   = 2 * EW;
    localparam int HW    = PHW + 1 - FRAC_BITS;
    localparam int QW    = PQW + 1 - FRAC_BITS;
    localparam int SW    = EW + QW + 2;
    localparam int DETW  = SW - 1;
    localparam int NW    = DETW + FRAC_BITS;
    localparam int DQ    = CW - 1;
    localparam int RW    = (NW > DETW + DQ) ? NW : DETW + DQ;
    localparam int EPW   = rti_pkg::EPS_WIDTH;
    localparam int EXW   = DQ + EPW;
    localparam int DATW  = rti_pkg::APB_DATA_WIDTH;
    localparam int AW    = rti_pkg::APB_ADDR_WIDTH;

    // Configuration registers.
    logic signed [CW-1:0] org_reg [3];
    logic signed [CW-1:0] dir_reg [3];
    logic [EPW-1:0]       det_eps_reg;
    logic [EPW-1:0]       dist_eps_reg;
    logic                 cfg_wr;
    rti_pkg::rti_reg_t    cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = rti_pkg::rti_reg_t'(paddr[AW-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0]   <= '0;
            org_reg[1]   <= '0;
            org_reg[2]   <= '0;
            dir_reg[0]   <= CW'(1) << FRAC_BITS;
            dir_reg[1]   <= '0;
            dir_reg[2]   <= '0;
            det_eps_reg  <= EPW'(1);
            dist_eps_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                rti_pkg::REG_ORG_X:    org_reg[0]   <= pwdata[CW-1:0];
                rti_pkg::REG_ORG_Y:    org_reg[1]   <= pwdata[CW-1:0];
                rti_pkg::REG_ORG_Z:    org_reg[2]   <= pwdata[CW-1:0];
                rti_pkg::REG_DIR_X:    dir_reg[0]   <= pwdata[CW-1:0];
                rti_pkg::REG_DIR_Y:    dir_reg[1]   <= pwdata[CW-1:0];
                rti_pkg::REG_DIR_Z:    dir_reg[2]   <= pwdata[CW-1:0];
                rti_pkg::REG_DET_EPS:  det_eps_reg  <= pwdata[EPW-1:0];
                rti_pkg::REG_DIST_EPS: dist_eps_reg <= pwdata[EPW-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            rti_pkg::REG_ORG_X:    prdata = DATW'($unsigned(org_reg[0]));
            rti_pkg::REG_ORG_Y:    prdata = DATW'($unsigned(org_reg[1]));
            rti_pkg::REG_ORG_Z:    prdata = DATW'($unsigned(org_reg[2]));
            rti_pkg::REG_DIR_X:    prdata = DATW'($unsigned(dir_reg[0]));
            rti_pkg::REG_DIR_Y:    prdata = DATW'($unsigned(dir_reg[1]));
            rti_pkg::REG_DIR_Z:    prdata = DATW'($unsigned(dir_reg[2]));
            rti_pkg::REG_DET_EPS:  prdata = DATW'(det_eps_reg);
            rti_pkg::REG_DIST_EPS: prdata = DATW'(dist_eps_reg);
        endcase
    end

    // Stage valids and the stall chain; a stage loads when it is empty or drains.
    logic [7:1] vld_reg;
    logic [7:1] up_vld;
    logic [7:1] en;
    logic       div_in_ready;

    assign up_vld = {vld_reg[6:1], triangle.valid};

    always_comb
    begin
        en[7] = !vld_reg[7] || div_in_ready;
        for (int k = 6; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign triangle.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= 7; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= up_vld[k];
                end
            end
        end
    end

    // Stage 1: edges and origin offset.
    logic signed [EW-1:0] e1_1_reg [3];
    logic signed [EW-1:0] e2_1_reg [3];
    logic signed [EW-1:0] s_1_reg  [3];
    rti_pkg::rti_norm_t   n1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            e1_1_reg[0] <= EW'(triangle.vert1_x) - EW'(triangle.vert0_x);
            e1_1_reg[1] <= EW'(triangle.vert1_y) - EW'(triangle.vert0_y);
            e1_1_reg[2] <= EW'(triangle.vert1_z) - EW'(triangle.vert0_z);
            e2_1_reg[0] <= EW'(triangle.vert2_x) - EW'(triangle.vert0_x);
            e2_1_reg[1] <= EW'(triangle.vert2_y) - EW'(triangle.vert0_y);
            e2_1_reg[2] <= EW'(triangle.vert2_z) - EW'(triangle.vert0_z);
            s_1_reg[0]  <= EW'(org_reg[0]) - EW'(triangle.vert0_x);
            s_1_reg[1]  <= EW'(org_reg[1]) - EW'(triangle.vert0_y);
            s_1_reg[2]  <= EW'(org_reg[2]) - EW'(triangle.vert0_z);
            n1_reg.x    <= triangle.face_norm_x;
            n1_reg.y    <= triangle.face_norm_y;
            n1_reg.z    <= triangle.face_norm_z;
        end
    end

    // Stage 2: cross product terms, h = dir x e2 and q = s x e1.
    logic signed [PHW-1:0] ph_reg [6];
    logic signed [PQW-1:0] pq_reg [6];
    logic signed [EW-1:0]  e1_2_reg [3];
    logic signed [EW-1:0]  e2_2_reg [3];
    logic signed [EW-1:0]  s_2_reg  [3];
    rti_pkg::rti_norm_t    n2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ph_reg[0] <= PHW'(dir_reg[1]) * PHW'(e2_1_reg[2]);
            ph_reg[1] <= PHW'(dir_reg[2]) * PHW'(e2_1_reg[1]);
            ph_reg[2] <= PHW'(dir_reg[2]) * PHW'(e2_1_reg[0]);
            ph_reg[3] <= PHW'(dir_reg[0]) * PHW'(e2_1_reg[2]);
            ph_reg[4] <= PHW'(dir_reg[0]) * PHW'(e2_1_reg[1]);
            ph_reg[5] <= PHW'(dir_reg[1]) * PHW'(e2_1_reg[0]);
            pq_reg[0] <= PQW'(s_1_reg[1]) * PQW'(e1_1_reg[2]);
            pq_reg[1] <= PQW'(s_1_reg[2]) * PQW'(e1_1_reg[1]);
            pq_reg[2] <= PQW'(s_1_reg[2]) * PQW'(e1_1_reg[0]);
            pq_reg[3] <= PQW'(s_1_reg[0]) * PQW'(e1_1_reg[2]);
            pq_reg[4] <= PQW'(s_1_reg[0]) * PQW'(e1_1_reg[1]);
            pq_reg[5] <= PQW'(s_1_reg[1]) * PQW'(e1_1_reg[0]);
            e1_2_reg  <= e1_1_reg;
            e2_2_reg  <= e2_1_reg;
            s_2_reg   <= s_1_reg;
            n2_reg    <= n1_reg;
        end
    end

    // Stage 3: differences scaled down by the fraction bits (floor).
    logic signed [PHW:0]  dh [3];
    logic signed [PQW:0]  dq [3];
    logic signed [HW-1:0] h_3_reg  [3];
    logic signed [QW-1:0] q_3_reg  [3];
    logic signed [EW-1:0] e1_3_reg [3];
    logic signed [EW-1:0] e2_3_reg [3];
    logic signed [EW-1:0] s_3_reg  [3];
    rti_pkg::rti_norm_t   n3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dh[i] = (PHW+1)'(ph_reg[2*i]) - (PHW+1)'(ph_reg[2*i+1]);
            dq[i] = (PQW+1)'(pq_reg[2*i]) - (PQW+1)'(pq_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                h_3_reg[i] <= dh[i][PHW:FRAC_BITS];
                q_3_reg[i] <= dq[i][PQW:FRAC_BITS];
            end
            e1_3_reg <= e1_2_reg;
            e2_3_reg <= e2_2_reg;
            s_3_reg  <= s_2_reg;
            n3_reg   <= n2_reg;
        end
    end

    // Stage 4: dot product terms.
    logic signed [SW-1:0] pdet_reg [3];
    logic signed [SW-1:0] pun_reg  [3];
    logic signed [SW-1:0] pvn_reg  [3];
    logic signed [SW-1:0] ptn_reg  [3];
    rti_pkg::rti_norm_t   n4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pdet_reg[i] <= SW'(e1_3_reg[i]) * SW'(h_3_reg[i]);
                pun_reg[i]  <= SW'(s_3_reg[i]) * SW'(h_3_reg[i]);
                pvn_reg[i]  <= SW'(dir_reg[i]) * SW'(q_3_reg[i]);
                ptn_reg[i]  <= SW'(e2_3_reg[i]) * SW'(q_3_reg[i]);
            end
            n4_reg <= n3_reg;
        end
    end

    // Stage 5: dot product sums.
    logic signed [SW-1:0] det_5_reg;
    logic signed [SW-1:0] un_5_reg;
    logic signed [SW-1:0] vn_5_reg;
    logic signed [SW-1:0] tn_5_reg;
    rti_pkg::rti_norm_t   n5_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            det_5_reg <= pdet_reg[0] + pdet_reg[1] + pdet_reg[2];
            un_5_reg  <= pun_reg[0] + pun_reg[1] + pun_reg[2];
            vn_5_reg  <= pvn_reg[0] + pvn_reg[1] + pvn_reg[2];
            tn_5_reg  <= ptn_reg[0] + ptn_reg[1] + ptn_reg[2];
            n5_reg    <= n4_reg;
        end
    end

    // Stage 6: make the determinant non-negative.
    logic                 det_neg;
    logic signed [SW-1:0] det_6_reg;
    logic signed [SW-1:0] un_6_reg;
    logic signed [SW-1:0] vn_6_reg;
    logic signed [SW-1:0] tn_6_reg;
    rti_pkg::rti_norm_t   n6_reg;

    assign det_neg = det_5_reg[SW-1];

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            det_6_reg <= det_neg ? -det_5_reg : det_5_reg;
            un_6_reg  <= det_neg ? -un_5_reg : un_5_reg;
            vn_6_reg  <= det_neg ? -vn_5_reg : vn_5_reg;
            tn_6_reg  <= det_neg ? -tn_5_reg : tn_5_reg;
            n6_reg    <= n5_reg;
        end
    end

    // Stage 7: parallel, barycentric and distance sign checks; divider operands.
    logic signed [SW-1:0] eps_s;
    logic signed [SW:0]   uv_sum;
    logic signed [SW:0]   det_x;
    logic                 miss_par;
    logic                 miss_u;
    logic                 miss_v;
    logic                 miss_t;
    logic [DETW-1:0]      det_u;
    logic [NW-1:0]        num;
    logic                 sat;
    rti_pkg::rti_side_t   side_7_reg;
    logic [DETW-1:0]      det_7_reg;
    logic [NW-1:0]        num_7_reg;

    assign eps_s    = SW'($signed({1'b0, det_eps_reg}));
    assign uv_sum   = (SW+1)'(un_6_reg) + (SW+1)'(vn_6_reg);
    assign det_x    = (SW+1)'(det_6_reg);
    assign miss_par = (det_6_reg == '0) || (det_6_reg < eps_s);
    assign miss_u   = un_6_reg[SW-1] || (un_6_reg > det_6_reg);
    assign miss_v   = vn_6_reg[SW-1] || (uv_sum > det_x);
    assign miss_t   = tn_6_reg[SW-1] || (tn_6_reg == '0);
    assign det_u    = det_6_reg[DETW-1:0];
    assign num      = {tn_6_reg[DETW-1:0], FRAC_BITS'(0)};
    assign sat      = RW'(num) >= (RW'(det_u) << DQ);

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            side_7_reg.ok   <= !(miss_par || miss_u || miss_v || miss_t);
            side_7_reg.sat  <= sat;
            side_7_reg.norm <= n6_reg;
            det_7_reg       <= det_u;
            num_7_reg       <= num;
        end
    end

    // Distance division, one quotient bit per stage.
    logic               div_out_valid;
    logic               out_en;
    rti_pkg::rti_side_t div_side;
    logic [DQ-1:0]      div_quo;

    rti_div #(
        .DET_W (DETW),
        .NUM_W (NW),
        .QUO_W (DQ)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[7]),
        .in_ready  (div_in_ready),
        .in_side   (side_7_reg),
        .in_det    (det_7_reg),
        .in_num    (num_7_reg),
        .out_valid (div_out_valid),
        .out_ready (out_en),
        .out_side  (div_side),
        .out_quo   (div_quo)
    );

    // Output register: saturation, near-hit rejection and zeroing on a miss.
    logic                 ovld_reg;
    logic                 hit_reg;
    logic [DQ-1:0]        dist_reg;
    rti_pkg::rti_norm_t   onorm_reg;
    logic [DQ-1:0]        t_sat;
    logic                 hit_next;

    assign out_en   = !ovld_reg || result.ready;
    assign t_sat    = div_side.sat ? '1 : div_quo;
    assign hit_next = div_side.ok && (EXW'(t_sat) > EXW'(dist_eps_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (out_en)
        begin
            ovld_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            hit_reg   <= hit_next;
            dist_reg  <= hit_next ? t_sat : '0;
            onorm_reg <= hit_next ? div_side.norm : '0;
        end
    end

    assign result.valid        = ovld_reg;
    assign result.hit          = hit_reg;
    assign result.hit_distance = dist_reg;
    assign result.hit_norm_x   = onorm_reg.x;
    assign result.hit_norm_y   = onorm_reg.y;
    assign result.hit_norm_z   = onorm_reg.z;

    `RTI_ASSERT_SAME(a_hit_beyond_eps, result.valid && result.hit,
        EXW'(result.hit_distance) > EXW'(dist_eps_reg), "hit at or below distance epsilon")
    `RTI_ASSERT_SAME(a_miss_zeroed, result.valid && !result.hit,
        result.hit_distance == '0 && result.hit_norm_x == '0 && result.hit_norm_y == '0 && result.hit_norm_z == '0, "miss word carries nonzero payload")
    `RTI_ASSERT_NEXT(a_accept_enters, triangle.valid && triangle.ready,
        vld_reg[1], "accepted triangle did not enter the first stage")

endmodule
